// ===== sv/ptq_pkg.sv =====
// Shared types and constants for the per-session turn queue.
// Holds the request and result payload structs, codes and state enums.
// No dependencies.
`default_nettype none
package ptq_pkg;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DONE    = 2'd1;
  localparam logic [1:0] OP_PURGE   = 2'd2;

  localparam logic [1:0] ACT_STATUS   = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_DISCARD  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int unsigned RQ_DEPTH = 4;

  localparam logic [4:0] USER_CAP_RESET = 5'd16;
  localparam logic [4:0] BG_CAP_RESET   = 5'd8;

  localparam logic REG_USER_CAP = 1'b0;
  localparam logic REG_BG_CAP   = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] session_key;
    logic        turn_source;
    logic [15:0] work_handle;
    logic        has_free_routine;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  status;
    logic [15:0] item_handle;
    logic        call_free;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_ENQ,
    CLS_ENQ_BAD,
    CLS_DONE,
    CLS_PURGE,
    CLS_BAD_OP
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] session_key;
    logic        turn_source;
    logic [15:0] work_handle;
    logic        has_free_routine;
  } cmd_t;

  typedef struct packed {
    logic        free_bit;
    logic [15:0] handle;
  } store_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MATCH,
    BK_RESOLVE,
    BK_EXEC,
    BK_READ,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== sv/ptq_front.sv =====
// Front end: accepts requests, classifies them and holds them in a
// two-entry command queue for the back end. Depends on ptq_pkg.
`default_nettype none
module ptq_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire ptq_pkg::in_item_t in_data,
  output logic                  cmd_valid,
  output ptq_pkg::cmd_t         cmd,
  input  wire logic             cmd_pop
);

  ptq_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  ptq_pkg::cmd_t cls_cmd;
  logic          do_push, do_pop;

  always_comb begin
    cls_cmd.session_key      = in_data.session_key;
    cls_cmd.turn_source      = in_data.turn_source;
    cls_cmd.work_handle      = in_data.work_handle;
    cls_cmd.has_free_routine = in_data.has_free_routine;
    case (in_data.operation)
      ptq_pkg::OP_ENQUEUE: begin
        if (in_data.session_key == 32'd0 || in_data.work_handle == 16'd0) begin
          cls_cmd.cls = ptq_pkg::CLS_ENQ_BAD;
        end else begin
          cls_cmd.cls = ptq_pkg::CLS_ENQ;
        end
      end
      ptq_pkg::OP_DONE:  cls_cmd.cls = ptq_pkg::CLS_DONE;
      ptq_pkg::OP_PURGE: cls_cmd.cls = ptq_pkg::CLS_PURGE;
      default:           cls_cmd.cls = ptq_pkg::CLS_BAD_OP;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= cls_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptq_resq.sv =====
// Result queue between the back end and the result ports.
// A small circular buffer of result items. Depends on ptq_pkg.
`default_nettype none
module ptq_resq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire ptq_pkg::out_item_t wr_item,
  output logic                    q_full,
  output logic                    q_empty,
  input  wire logic               rd_en,
  output ptq_pkg::out_item_t      rd_item
);

  localparam int unsigned PW = $clog2(ptq_pkg::RQ_DEPTH);

  ptq_pkg::out_item_t buf_r [ptq_pkg::RQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (cnt_r == (PW+1)'(ptq_pkg::RQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_item = buf_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(do_wr) - (PW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      buf_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptq_back.sv =====
// Back end: session table, per-slot FIFO store and the sequencer that
// carries out each request. Depends on ptq_pkg.
`default_nettype none
module ptq_back #(
  parameter int unsigned SESSION_SLOTS = 32,
  parameter int unsigned QUEUE_DEPTH   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  input  wire ptq_pkg::cmd_t      cmd,
  output logic                    cmd_pop,
  input  wire logic [4:0]         user_cap,
  input  wire logic [4:0]         bg_cap,
  output logic                    rq_push,
  output ptq_pkg::out_item_t      rq_item,
  input  wire logic               rq_full
);

  localparam int unsigned SW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KW = (CW > 5) ? CW : 5;
  localparam int unsigned ENTRIES = SESSION_SLOTS * QUEUE_DEPTH;
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ptq_pkg::back_state_t state_r, state_nxt;

  logic [31:0]      sess_r  [SESSION_SLOTS];
  logic [CW-1:0]    count_r [SESSION_SLOTS];
  logic [PW-1:0]    head_r  [SESSION_SLOTS];
  logic [PW-1:0]    tail_r  [SESSION_SLOTS];
  logic [SESSION_SLOTS-1:0] busy_r, closing_r;
  logic [SESSION_SLOTS-1:0] match_r, free_r;

  ptq_pkg::cmd_t        cmd_r;
  logic [SW-1:0]        slot_r;
  logic                 hit_r, avail_r, alloc_r, drain_r;
  ptq_pkg::store_entry_t store_mem [ENTRIES];
  ptq_pkg::store_entry_t rd_data_r;

  logic [SW-1:0]  hit_idx, free_idx;
  logic           hit_any, free_any;
  logic           cur_busy, cur_closing;
  logic [CW-1:0]  cur_count;
  logic [PW-1:0]  cur_head, cur_tail;
  logic [CW-1:0]  cap_lim;
  logic [4:0]     cap_sel;
  logic           enq_ok, cap_hit;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic           go_read, retire_now, last_item;

  function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    return r;
  endfunction

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    hit_any  = 1'b0;
    free_any = 1'b0;
    for (int i = SESSION_SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = SW'(i);
        hit_any = 1'b1;
      end
      if (free_r[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    cur_busy    = hit_r ? busy_r[slot_r] : 1'b0;
    cur_closing = hit_r ? closing_r[slot_r] : 1'b0;
    cur_count   = hit_r ? count_r[slot_r] : '0;
    cur_head    = hit_r ? head_r[slot_r] : '0;
    cur_tail    = hit_r ? tail_r[slot_r] : '0;
    cap_sel     = cmd_r.turn_source ? bg_cap : user_cap;
    cap_lim     = (KW'(cap_sel) > KW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(cap_sel);
    cap_hit     = (cur_count >= cap_lim);
    enq_ok      = avail_r && !cur_closing && !cap_hit;
    mem_waddr   = AW'(slot_r) * AW'(QUEUE_DEPTH) + AW'(cur_tail);
    mem_raddr   = AW'(slot_r) * AW'(QUEUE_DEPTH) + AW'(head_r[slot_r]);
    last_item   = (count_r[slot_r] == CW'(1));
    go_read     = 1'b0;
    retire_now  = 1'b0;
    case (cmd_r.cls)
      ptq_pkg::CLS_DONE: begin
        go_read = hit_r && (cur_count != '0);
      end
      ptq_pkg::CLS_PURGE: begin
        go_read = hit_r && (cur_count != '0);
      end
      default: begin
        go_read = 1'b0;
      end
    endcase
    retire_now = hit_r && (cur_count == '0);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptq_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          state_nxt = ptq_pkg::BK_MATCH;
        end
      end
      ptq_pkg::BK_MATCH:   state_nxt = ptq_pkg::BK_RESOLVE;
      ptq_pkg::BK_RESOLVE: state_nxt = ptq_pkg::BK_EXEC;
      ptq_pkg::BK_EXEC: begin
        if (!rq_full) begin
          state_nxt = go_read ? ptq_pkg::BK_READ : ptq_pkg::BK_IDLE;
        end
      end
      ptq_pkg::BK_READ: state_nxt = ptq_pkg::BK_EMIT;
      ptq_pkg::BK_EMIT: begin
        if (!rq_full) begin
          state_nxt = (!drain_r || last_item) ? ptq_pkg::BK_IDLE : ptq_pkg::BK_READ;
        end
      end
      default: state_nxt = ptq_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    rq_push = 1'b0;
    rq_item = '{action: ptq_pkg::ACT_STATUS, status: ptq_pkg::ST_OK,
                item_handle: 16'd0, call_free: 1'b0, last: 1'b1};
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    case (state_r)
      ptq_pkg::BK_IDLE: begin
        cmd_pop = cmd_valid;
      end
      ptq_pkg::BK_EXEC: begin
        rq_push = !rq_full && !go_read;
        case (cmd_r.cls)
          ptq_pkg::CLS_ENQ: begin
            if (!avail_r || cur_closing) begin
              rq_item.status = ptq_pkg::ST_FAIL;
            end else if (cap_hit) begin
              rq_item.status = ptq_pkg::ST_FULL;
            end else begin
              mem_we = !rq_full;
              if (!cur_busy) begin
                rq_item.action      = ptq_pkg::ACT_DISPATCH;
                rq_item.item_handle = cmd_r.work_handle;
              end
            end
          end
          ptq_pkg::CLS_ENQ_BAD: rq_item.status = ptq_pkg::ST_FAIL;
          ptq_pkg::CLS_BAD_OP:  rq_item.status = ptq_pkg::ST_FAIL;
          default:              rq_item.status = ptq_pkg::ST_OK;
        endcase
      end
      ptq_pkg::BK_READ: begin
        mem_re = 1'b1;
      end
      ptq_pkg::BK_EMIT: begin
        rq_push             = !rq_full;
        rq_item.item_handle = rd_data_r.handle;
        if (drain_r) begin
          rq_item.action    = ptq_pkg::ACT_DISCARD;
          rq_item.call_free = rd_data_r.free_bit;
          rq_item.last      = last_item;
        end else begin
          rq_item.action = ptq_pkg::ACT_DISPATCH;
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptq_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= '{free_bit: cmd_r.has_free_routine,
                                handle: cmd_r.work_handle};
    end
    if (mem_re) begin
      rd_data_r <= store_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ptq_pkg::BK_IDLE && cmd_valid) begin
      cmd_r <= cmd;
    end
    if (state_r == ptq_pkg::BK_MATCH) begin
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        match_r[i] <= (sess_r[i] == cmd_r.session_key) && (cmd_r.session_key != 32'd0);
        free_r[i]  <= (sess_r[i] == 32'd0);
      end
    end
    if (state_r == ptq_pkg::BK_RESOLVE) begin
      slot_r  <= hit_any ? hit_idx : free_idx;
      hit_r   <= hit_any;
      avail_r <= hit_any || free_any;
      alloc_r <= !hit_any && free_any;
    end
    if (state_r == ptq_pkg::BK_EXEC) begin
      drain_r <= closing_r[slot_r] || (cmd_r.cls == ptq_pkg::CLS_PURGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        sess_r[i]  <= '0;
        count_r[i] <= '0;
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
      end
      busy_r    <= '0;
      closing_r <= '0;
    end else if (state_r == ptq_pkg::BK_EXEC && !rq_full) begin
      case (cmd_r.cls)
        ptq_pkg::CLS_ENQ: begin
          if (enq_ok) begin
            sess_r[slot_r]    <= cmd_r.session_key;
            closing_r[slot_r] <= 1'b0;
            tail_r[slot_r]    <= wrap_next(cur_tail);
            if (!cur_busy) begin
              busy_r[slot_r]  <= 1'b1;
              head_r[slot_r]  <= wrap_next(cur_head);
              count_r[slot_r] <= cur_count;
            end else begin
              count_r[slot_r] <= cur_count + CW'(1);
            end
          end else if (alloc_r) begin
            sess_r[slot_r]    <= cmd_r.session_key;
            busy_r[slot_r]    <= 1'b0;
            closing_r[slot_r] <= 1'b0;
            count_r[slot_r]   <= '0;
            head_r[slot_r]    <= '0;
            tail_r[slot_r]    <= '0;
          end
        end
        ptq_pkg::CLS_DONE: begin
          if (retire_now) begin
            sess_r[slot_r]    <= '0;
            busy_r[slot_r]    <= 1'b0;
            closing_r[slot_r] <= 1'b0;
            head_r[slot_r]    <= '0;
            tail_r[slot_r]    <= '0;
          end
        end
        ptq_pkg::CLS_PURGE: begin
          if (retire_now) begin
            head_r[slot_r] <= '0;
            tail_r[slot_r] <= '0;
            if (cur_busy) begin
              closing_r[slot_r] <= 1'b1;
            end else begin
              sess_r[slot_r]    <= '0;
              closing_r[slot_r] <= 1'b0;
            end
          end
        end
        default: begin
          busy_r <= busy_r;
        end
      endcase
    end else if (state_r == ptq_pkg::BK_EMIT && !rq_full) begin
      count_r[slot_r] <= count_r[slot_r] - CW'(1);
      if (!drain_r) begin
        busy_r[slot_r] <= 1'b1;
        head_r[slot_r] <= wrap_next(head_r[slot_r]);
      end else if (last_item) begin
        head_r[slot_r] <= '0;
        tail_r[slot_r] <= '0;
        if (cmd_r.cls == ptq_pkg::CLS_DONE || !busy_r[slot_r]) begin
          sess_r[slot_r]    <= '0;
          busy_r[slot_r]    <= 1'b0;
          closing_r[slot_r] <= 1'b0;
        end else begin
          closing_r[slot_r] <= 1'b1;
        end
      end else begin
        head_r[slot_r] <= wrap_next(head_r[slot_r]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/per_session_turn_queue_unit.sv =====
// An enqueue or a status-only request passes the match, resolve and execute states before its result
// enters the result queue; each dispatch or discard read from the store adds a read and an emit state.
// The session lookup sequencer takes a new request only once it is through with the last one.
// A purge or closing turn-done drains one result at a time, each read from the store and then emitted.
// Reset (rst_n low, synchronous) frees all slots, empties both queues and restores the caps.
// Top level: config registers, front end, back end and result queue. Depends on ptq_pkg.
`default_nettype none
module per_session_turn_queue_unit #(
  parameter int unsigned SESSION_SLOTS = 32,
  parameter int unsigned QUEUE_DEPTH   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire ptq_pkg::in_item_t  in_data,
  output logic                    empty,
  input  wire logic               pop,
  output ptq_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [4:0]          user_cap_r, bg_cap_r;
  logic                cmd_valid, cmd_pop, rq_push, rq_full;
  ptq_pkg::cmd_t       cmd;
  ptq_pkg::out_item_t  rq_item;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      ptq_pkg::REG_USER_CAP: prdata = {27'd0, user_cap_r};
      default:               prdata = {27'd0, bg_cap_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_cap_r <= ptq_pkg::USER_CAP_RESET;
      bg_cap_r   <= ptq_pkg::BG_CAP_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == ptq_pkg::REG_USER_CAP) begin
        user_cap_r <= pwdata[4:0];
      end else begin
        bg_cap_r <= pwdata[4:0];
      end
    end
  end

  ptq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ptq_back #(
    .SESSION_SLOTS (SESSION_SLOTS),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .user_cap  (user_cap_r),
    .bg_cap    (bg_cap_r),
    .rq_push   (rq_push),
    .rq_item   (rq_item),
    .rq_full   (rq_full)
  );

  ptq_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rq_push),
    .wr_item (rq_item),
    .q_full  (rq_full),
    .q_empty (empty),
    .rd_en   (pop),
    .rd_item (out_data)
  );

endmodule
`default_nettype wire

// ===== sv/ptq_check.sv =====
// Port-level checker for the per-session turn queue unit, with its bind.
// Depends on ptq_pkg and per_session_turn_queue_unit.
`default_nettype none
module ptq_check (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              empty,
  input wire logic              pop,
  input wire ptq_pkg::out_item_t out_data,
  input wire logic              pready
);

  a_dispatch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.action == ptq_pkg::ACT_DISPATCH) |->
      (out_data.status == ptq_pkg::ST_OK && !out_data.call_free))
    else $error("A dispatched request carries a status or a release flag.");

  a_status_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.action == ptq_pkg::ACT_STATUS) |->
      (out_data.item_handle == 16'd0 && out_data.last))
    else $error("A status-only result carries a handle or is not final.");

  a_free_on_discard: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.call_free) |-> (out_data.action == ptq_pkg::ACT_DISCARD))
    else $error("The release flag is set on a result that is not a discard.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("A waiting result changed before it was taken.");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("The configuration port is not ready.");

endmodule

bind per_session_turn_queue_unit ptq_check u_ptq_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data),
  .pready   (pready)
);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the per-session turn queue unit.
// Predicts every result from its own model of the session slots and checks each one.
// Depends on ptq_pkg and per_session_turn_queue_unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int NSLOT = 32;
  localparam int QDEP  = 16;
  localparam int LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  ptq_pkg::in_item_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  ptq_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  per_session_turn_queue_unit uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [31:0] sess_id [NSLOT];
  logic sess_busy [NSLOT];
  logic sess_closing [NSLOT];
  int sess_count [NSLOT];
  int sess_head [NSLOT];
  int sess_tail [NSLOT];
  logic [15:0] fifo_handle [NSLOT*QDEP];
  logic fifo_free [NSLOT*QDEP];
  logic [4:0] cap_user;
  logic [4:0] cap_bg;

  ptq_pkg::out_item_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  logic [31:0] recent_ids [$];

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
  endtask

  // The receiver pops with random stalls, or holds off while hold_off is set.
  always @(posedge clk) begin
    ptq_pkg::out_item_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 32'(out_data), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.action !== want.action)
          report("action", 32'(out_data.action), 32'(want.action));
        if (out_data.status !== want.status)
          report("status", 32'(out_data.status), 32'(want.status));
        if (out_data.item_handle !== want.item_handle)
          report("item_handle", 32'(out_data.item_handle), 32'(want.item_handle));
        if (out_data.call_free !== want.call_free)
          report("call_free", 32'(out_data.call_free), 32'(want.call_free));
        if (out_data.last !== want.last)
          report("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        pop <= 1'b0;
        hold_off--;
      end else if (pop && !empty) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 13));
        if (gap == 0) begin
          pop <= 1'b1;
        end else begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
          pop <= 1'b1;
        end
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic ptq_pkg::out_item_t mk(input logic [1:0] act, input logic [1:0] st,
                                            input logic [15:0] h, input logic fr);
    ptq_pkg::out_item_t r;
    r.action = act;
    r.status = st;
    r.item_handle = h;
    r.call_free = fr;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic int find_session(input logic [31:0] sid);
    if (sid == 32'd0) return -1;
    for (int i = 0; i < NSLOT; i++) if (sess_id[i] == sid) return i;
    return -1;
  endfunction

  function automatic void take_head(input int s, output logic [15:0] h, output logic fr);
    h = fifo_handle[s*QDEP + sess_head[s]];
    fr = fifo_free[s*QDEP + sess_head[s]];
    sess_head[s] = (sess_head[s] + 1) % QDEP;
    sess_count[s]--;
  endfunction

  function automatic void discard_all(input int s, ref ptq_pkg::out_item_t res [$]);
    logic [15:0] h;
    logic fr;
    while (sess_count[s] > 0) begin
      take_head(s, h, fr);
      res.push_back(mk(ptq_pkg::ACT_DISCARD, ptq_pkg::ST_OK, h, fr));
    end
    sess_head[s] = 0;
    sess_tail[s] = 0;
  endfunction

  function automatic void predict_turn(input ptq_pkg::in_item_t it);
    ptq_pkg::out_item_t res [$];
    int s;
    int cap;
    logic [15:0] h;
    logic fr;
    s = find_session(it.session_key);
    if (it.operation == ptq_pkg::OP_ENQUEUE) begin
      if (it.session_key == 32'd0 || it.work_handle == 16'd0) begin
        res.push_back(mk(ptq_pkg::ACT_STATUS, ptq_pkg::ST_FAIL, 16'd0, 1'b0));
      end else begin
        if (s < 0) begin
          for (int i = 0; i < NSLOT; i++) if (s < 0 && sess_id[i] == 32'd0) s = i;
          if (s >= 0) begin
            sess_id[s] = it.session_key;
            sess_busy[s] = 1'b0;
            sess_closing[s] = 1'b0;
            sess_count[s] = 0;
            sess_head[s] = 0;
            sess_tail[s] = 0;
          end
        end
        cap = it.turn_source ? int'(cap_bg) : int'(cap_user);
        if (cap > QDEP) cap = QDEP;
        if (s < 0 || sess_closing[s]) begin
          res.push_back(mk(ptq_pkg::ACT_STATUS, ptq_pkg::ST_FAIL, 16'd0, 1'b0));
        end else if (sess_count[s] >= cap) begin
          res.push_back(mk(ptq_pkg::ACT_STATUS, ptq_pkg::ST_FULL, 16'd0, 1'b0));
        end else begin
          fifo_handle[s*QDEP + sess_tail[s]] = it.work_handle;
          fifo_free[s*QDEP + sess_tail[s]] = it.has_free_routine;
          sess_tail[s] = (sess_tail[s] + 1) % QDEP;
          sess_count[s]++;
          if (!sess_busy[s]) begin
            sess_busy[s] = 1'b1;
            take_head(s, h, fr);
            res.push_back(mk(ptq_pkg::ACT_DISPATCH, ptq_pkg::ST_OK, h, 1'b0));
          end else begin
            res.push_back(mk(ptq_pkg::ACT_STATUS, ptq_pkg::ST_OK, 16'd0, 1'b0));
          end
        end
      end
    end else if (it.operation == ptq_pkg::OP_DONE) begin
      if (s >= 0) begin
        if (sess_closing[s]) begin
          discard_all(s, res);
          sess_busy[s] = 1'b0;
          sess_closing[s] = 1'b0;
          sess_id[s] = 32'd0;
        end else if (sess_count[s] > 0) begin
          take_head(s, h, fr);
          sess_busy[s] = 1'b1;
          res.push_back(mk(ptq_pkg::ACT_DISPATCH, ptq_pkg::ST_OK, h, 1'b0));
        end else begin
          sess_busy[s] = 1'b0;
          sess_id[s] = 32'd0;
        end
      end
      if (res.size() == 0)
        res.push_back(mk(ptq_pkg::ACT_STATUS, ptq_pkg::ST_OK, 16'd0, 1'b0));
    end else if (it.operation == ptq_pkg::OP_PURGE) begin
      if (s >= 0) begin
        discard_all(s, res);
        sess_closing[s] = 1'b1;
        if (!sess_busy[s]) begin
          sess_id[s] = 32'd0;
          sess_closing[s] = 1'b0;
        end
      end
      if (res.size() == 0)
        res.push_back(mk(ptq_pkg::ACT_STATUS, ptq_pkg::ST_OK, 16'd0, 1'b0));
    end else begin
      res.push_back(mk(ptq_pkg::ACT_STATUS, ptq_pkg::ST_FAIL, 16'd0, 1'b0));
    end
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endfunction

  task automatic send_request(input ptq_pkg::in_item_t it, input bit no_gap = 1'b0);
    int gap;
    gap = (no_gap || $urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    predict_turn(it);
  endtask

  task automatic send(input logic [1:0] op, input logic [31:0] sid, input logic src,
                      input logic [15:0] wh, input logic fr);
    ptq_pkg::in_item_t it;
    it.operation = op;
    it.session_key = sid;
    it.turn_source = src;
    it.work_handle = wh;
    it.has_free_routine = fr;
    send_request(it);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cap(input logic reg_index, input logic [4:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= {$urandom_range(0, 1) ? 27'h7ffffff : 27'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {27'd0, value}) report("config readback", prdata, {27'd0, value});
    if (pready !== 1'b1) report("pready", 32'(pready), 32'd1);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_index == ptq_pkg::REG_USER_CAP) cap_user = value;
    else cap_bg = value;
  endtask

  task automatic test_directed();
    send(ptq_pkg::OP_ENQUEUE, 32'hffffffff, 1'b0, 16'hffff, 1'b1);
    send(ptq_pkg::OP_ENQUEUE, 32'hffffffff, 1'b1, 16'h0001, 1'b1);
    send(ptq_pkg::OP_ENQUEUE, 32'hffffffff, 1'b0, 16'h8000, 1'b0);
    send(ptq_pkg::OP_ENQUEUE, 32'h0, 1'b0, 16'h1234, 1'b0);
    send(ptq_pkg::OP_ENQUEUE, 32'h5, 1'b0, 16'h0, 1'b1);
    send(ptq_pkg::OP_DONE, 32'hffffffff, 1'b0, 16'h0, 1'b0);
    send(ptq_pkg::OP_PURGE, 32'hffffffff, 1'b1, 16'hffff, 1'b1);
    send(ptq_pkg::OP_ENQUEUE, 32'hffffffff, 1'b0, 16'h0042, 1'b0);
    send(ptq_pkg::OP_DONE, 32'hffffffff, 1'b0, 16'h0, 1'b0);
    send(ptq_pkg::OP_DONE, 32'hffffffff, 1'b0, 16'h0, 1'b0);
    send(ptq_pkg::OP_DONE, 32'h0, 1'b0, 16'h0, 1'b0);
    send(ptq_pkg::OP_PURGE, 32'h0, 1'b0, 16'h0, 1'b0);
    send(ptq_pkg::OP_DONE, 32'h77, 1'b0, 16'h0, 1'b0);
    send(ptq_pkg::OP_PURGE, 32'h77, 1'b0, 16'h0, 1'b0);
    send(OP_UNUSED, 32'h1, 1'b1, 16'h5555, 1'b1);
    send(ptq_pkg::OP_ENQUEUE, 32'h9, 1'b0, 16'h0009, 1'b1);
    send(ptq_pkg::OP_PURGE, 32'h9, 1'b0, 16'h0, 1'b0);
    send(ptq_pkg::OP_DONE, 32'h9, 1'b0, 16'h0, 1'b0);
    send(ptq_pkg::OP_ENQUEUE, 32'h9, 1'b0, 16'h0019, 1'b0);
    send(ptq_pkg::OP_PURGE, 32'h9, 1'b0, 16'h0, 1'b0);
    wait_idle();
  endtask

  task automatic test_slot_exhaustion();
    for (int i = 1; i <= NSLOT + 1; i++)
      send(ptq_pkg::OP_ENQUEUE, 32'h1000 + i, 1'b0, 16'(i), 1'b0);
    for (int i = 1; i <= NSLOT; i++)
      send(ptq_pkg::OP_DONE, 32'h1000 + i, 1'b0, 16'h0, 1'b0);
    wait_idle();
  endtask

  task automatic test_caps_and_backpressure(input logic [4:0] ucap, input logic [4:0] bcap);
    logic [31:0] sid;
    ptq_pkg::in_item_t it;
    write_cap(ptq_pkg::REG_USER_CAP, ucap);
    write_cap(ptq_pkg::REG_BG_CAP, bcap);
    sid = $urandom_range(1, 32'hfffffffe);
    @(posedge clk);
    hold_off = 300;
    for (int i = 0; i < 18; i++) begin
      it.operation = ptq_pkg::OP_ENQUEUE;
      it.session_key = sid;
      it.turn_source = i[0];
      it.work_handle = 16'($urandom_range(1, 16'hffff));
      it.has_free_routine = 1'($urandom_range(0, 1));
      send_request(it, 1'b1);
    end
    send(ptq_pkg::OP_PURGE, sid, 1'b0, 16'h0, 1'b0);
    send(ptq_pkg::OP_DONE, sid, 1'b0, 16'h0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random(input int n);
    ptq_pkg::in_item_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = int'($urandom_range(0, 99));
      if (recent_ids.size() == 0 || $urandom_range(0, 9) == 0)
        recent_ids.push_back($urandom());
      if (recent_ids.size() > 6) void'(recent_ids.pop_front());
      it.session_key = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      it.turn_source = 1'($urandom_range(0, 1));
      it.work_handle = 16'($urandom());
      it.has_free_routine = 1'($urandom_range(0, 1));
      if (pick < 60) it.operation = ptq_pkg::OP_ENQUEUE;
      else if (pick < 82) it.operation = ptq_pkg::OP_DONE;
      else if (pick < 95) it.operation = ptq_pkg::OP_PURGE;
      else it.operation = OP_UNUSED;
      if (pick >= 97) it.session_key = (pick == 99) ? 32'h0 : $urandom();
      if (pick == 98) it.work_handle = 16'h0;
      send_request(it);
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      sess_id[i] = 32'd0;
      sess_busy[i] = 1'b0;
      sess_closing[i] = 1'b0;
      sess_count[i] = 0;
      sess_head[i] = 0;
      sess_tail[i] = 0;
    end
    cap_user = ptq_pkg::USER_CAP_RESET;
    cap_bg = ptq_pkg::BG_CAP_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_slot_exhaustion();
    test_caps_and_backpressure(5'd31, 5'd0);
    test_caps_and_backpressure(5'd1, 5'd16);
    test_caps_and_backpressure(5'd17, 5'd3);
    test_random(30);
    write_cap(ptq_pkg::REG_USER_CAP, 5'd4);
    write_cap(ptq_pkg::REG_BG_CAP, 5'd2);
    test_random(30);
    write_cap(ptq_pkg::REG_USER_CAP, ptq_pkg::USER_CAP_RESET);
    write_cap(ptq_pkg::REG_BG_CAP, ptq_pkg::BG_CAP_RESET);
    test_random(27);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== per_session_turn_queue_unit.f =====
sv/ptq_pkg.sv
sv/ptq_front.sv
sv/ptq_resq.sv
sv/ptq_back.sv
sv/per_session_turn_queue_unit.sv
sv/ptq_check.sv
bench/testbench.sv
